// ===== src/mecm_pkg.sv =====
// ----------------------------------------------------------------------------
// mecm_pkg - shared types and constants
// Frame layout, command codes, register indexes and the records passed
// between the front, the engine and the result queue.
// ----------------------------------------------------------------------------
`default_nettype none

package mecm_pkg;

  localparam int ADDR_BITS  = 10;
  localparam int DATA_BITS  = 16;
  localparam int FRAME_BITS = 3 + ADDR_BITS + DATA_BITS;
  localparam int CNT_BITS   = 5;   // holds FRAME_BITS
  localparam int CFG_BITS   = 16;

  // command codes
  localparam logic [2:0] CMD_READ  = 3'd0;
  localparam logic [2:0] CMD_WRITE = 3'd1;
  localparam logic [2:0] CMD_EWEN  = 3'd2;
  localparam logic [2:0] CMD_EWDS  = 3'd3;
  localparam logic [2:0] CMD_ERASE = 3'd4;
  localparam logic [2:0] CMD_ERAL  = 3'd5;
  localparam logic [2:0] CMD_BUSY  = 3'd6;

  // start bit plus opcode
  localparam logic [2:0] OP_READ  = 3'b110;
  localparam logic [2:0] OP_WRITE = 3'b101;
  localparam logic [2:0] OP_EXT   = 3'b100;
  localparam logic [2:0] OP_ERASE = 3'b111;

  // extended-opcode address patterns
  localparam logic [ADDR_BITS-1:0] ADDR_EWEN = {2'b11, {(ADDR_BITS-2){1'b0}}};
  localparam logic [ADDR_BITS-1:0] ADDR_EWDS = '0;
  localparam logic [ADDR_BITS-1:0] ADDR_ERAL = {2'b10, {(ADDR_BITS-2){1'b0}}};

  localparam logic [CNT_BITS-1:0] LEN_LONG  = CNT_BITS'(FRAME_BITS);
  localparam logic [CNT_BITS-1:0] LEN_SHORT = CNT_BITS'(3 + ADDR_BITS);
  localparam logic [CNT_BITS-1:0] DATA_CNT  = CNT_BITS'(DATA_BITS);

  // configuration register indexes
  localparam logic CFG_POLL_INTERVAL = 1'b0;
  localparam logic CFG_POLL_LIMIT    = 1'b1;

  localparam logic [CFG_BITS-1:0] POLL_INTERVAL_RST = 16'd100;
  localparam logic [CFG_BITS-1:0] POLL_LIMIT_RST    = 16'd10000;

  typedef enum logic {
    ITEM_START = 1'b0,
    ITEM_TICK  = 1'b1
  } item_kind_t;

  typedef struct packed {
    item_kind_t                kind;
    logic [2:0]                cmd;
    logic [FRAME_BITS-1:0]     frame;
    logic [CNT_BITS-1:0]       len;
    logic                      sdo;
  } item_t;

  typedef struct packed {
    logic                  chip_select;
    logic                  data_out_bit;
    logic                  clock_pulse;
    logic                  frame_done;
    logic [DATA_BITS-1:0]  read_value;
    logic                  status;
  } res_t;

  function automatic logic [FRAME_BITS-1:0] frame_word(
    input logic [2:0]           op,
    input logic [ADDR_BITS-1:0] addr,
    input logic [DATA_BITS-1:0] data
  );
    frame_word = {op, addr, data};
  endfunction

endpackage

`default_nettype wire

// ===== src/mecm_front.sv =====
// ----------------------------------------------------------------------------
// mecm_front - input stage
// Accepts items, builds the frame pattern for commands, drops unknown
// commands and holds the classified items in a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module mecm_front (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_push,
  output logic                                 in_full,
  input  wire logic                            in_func,
  input  wire logic [2:0]                      in_command,
  input  wire logic [mecm_pkg::ADDR_BITS-1:0]  in_address,
  input  wire logic [mecm_pkg::DATA_BITS-1:0]  in_write_data,
  input  wire logic                            in_sdo,
  output logic                                 q_valid,
  output mecm_pkg::item_t                      q_item,
  input  wire logic                            q_pop
);

  mecm_pkg::item_t item;
  logic            keep;
  logic            push_en;

  mecm_pkg::item_t mem_r [2];
  logic            wr_ptr_r, wr_ptr_nxt;
  logic            rd_ptr_r, rd_ptr_nxt;
  logic [1:0]      cnt_r, cnt_nxt;

  // classify
  always_comb begin
    item       = '0;
    keep       = 1'b1;
    item.sdo   = in_sdo;
    item.cmd   = in_command;
    item.len   = mecm_pkg::LEN_SHORT;
    if (in_func) begin
      item.kind = mecm_pkg::ITEM_TICK;
    end else begin
      item.kind = mecm_pkg::ITEM_START;
      case (in_command)
        mecm_pkg::CMD_READ: begin
          item.frame = mecm_pkg::frame_word(mecm_pkg::OP_READ, in_address, '0);
          item.len   = mecm_pkg::LEN_LONG;
        end
        mecm_pkg::CMD_WRITE: begin
          item.frame = mecm_pkg::frame_word(mecm_pkg::OP_WRITE, in_address, in_write_data);
          item.len   = mecm_pkg::LEN_LONG;
        end
        mecm_pkg::CMD_EWEN:
          item.frame = mecm_pkg::frame_word(mecm_pkg::OP_EXT, mecm_pkg::ADDR_EWEN, '0);
        mecm_pkg::CMD_EWDS:
          item.frame = mecm_pkg::frame_word(mecm_pkg::OP_EXT, mecm_pkg::ADDR_EWDS, '0);
        mecm_pkg::CMD_ERASE:
          item.frame = mecm_pkg::frame_word(mecm_pkg::OP_ERASE, in_address, '0);
        mecm_pkg::CMD_ERAL:
          item.frame = mecm_pkg::frame_word(mecm_pkg::OP_EXT, mecm_pkg::ADDR_ERAL, '0);
        mecm_pkg::CMD_BUSY: begin
          item.frame = '0;
          item.len   = '0;
        end
        default: keep = 1'b0;   // unknown command has no effect
      endcase
    end
  end

  assign in_full = (cnt_r == 2'd2);
  assign push_en = in_push && !in_full && keep;
  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push_en;
    rd_ptr_nxt = rd_ptr_r ^ q_pop;
    cnt_nxt    = cnt_r + {1'b0, push_en} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_en) begin
      mem_r[wr_ptr_r] <= item;
    end
  end

endmodule

`default_nettype wire

// ===== src/mecm_engine.sv =====
// ----------------------------------------------------------------------------
// mecm_engine - frame sequencer
// Holds the frame state and poll registers, runs one queued item per cycle
// unless a tick meets a full result queue; one pin-slot result per tick.
// ----------------------------------------------------------------------------
`default_nettype none

module mecm_engine (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic                            cfg_index,
  input  wire logic [mecm_pkg::CFG_BITS-1:0]   cfg_data,
  input  wire logic                            q_valid,
  input  wire mecm_pkg::item_t                 q_item,
  output logic                                 q_pop,
  input  wire logic                            res_full,
  output logic                                 res_push,
  output mecm_pkg::res_t                       res
);

  logic [mecm_pkg::CFG_BITS-1:0]    poll_interval_r;
  logic [mecm_pkg::CFG_BITS-1:0]    poll_limit_r;

  logic                             active_r, active_nxt;
  logic [2:0]                       cmd_r, cmd_nxt;
  logic [mecm_pkg::FRAME_BITS-1:0]  out_shift_r, out_shift_nxt;
  logic [mecm_pkg::CNT_BITS-1:0]    bit_cnt_r, bit_cnt_nxt;
  logic [mecm_pkg::DATA_BITS-1:0]   in_shift_r, in_shift_nxt;
  logic [mecm_pkg::CFG_BITS-1:0]    poll_rem_r, poll_rem_nxt;
  logic [mecm_pkg::CFG_BITS-1:0]    ivl_cnt_r, ivl_cnt_nxt;

  logic is_tick;
  logic done;

  assign is_tick  = (q_item.kind == mecm_pkg::ITEM_TICK);
  assign q_pop    = q_valid && (!is_tick || !res_full);
  assign res_push = q_pop && is_tick;

  always_comb begin
    active_nxt    = active_r;
    cmd_nxt       = cmd_r;
    out_shift_nxt = out_shift_r;
    bit_cnt_nxt   = bit_cnt_r;
    in_shift_nxt  = in_shift_r;
    poll_rem_nxt  = poll_rem_r;
    ivl_cnt_nxt   = ivl_cnt_r;
    done          = 1'b0;
    res           = '0;

    if (q_pop) begin
      if (!is_tick) begin
        if (!active_r) begin
          active_nxt    = 1'b1;
          cmd_nxt       = q_item.cmd;
          out_shift_nxt = q_item.frame;
          bit_cnt_nxt   = q_item.len;
          in_shift_nxt  = '0;
          poll_rem_nxt  = poll_limit_r;
          ivl_cnt_nxt   = '0;
        end
      end else if (active_r) begin
        res.chip_select = 1'b1;
        if (cmd_r == mecm_pkg::CMD_BUSY) begin
          if (ivl_cnt_r == '0) begin
            // limit checked before the ready sample
            poll_rem_nxt = poll_rem_r - 1'b1;
            if (poll_rem_nxt == '0) begin
              done       = 1'b1;
              res.status = 1'b1;
            end else if (q_item.sdo) begin
              done = 1'b1;
            end else begin
              ivl_cnt_nxt = (poll_interval_r == '0) ? '0 : poll_interval_r - 1'b1;
            end
          end else begin
            ivl_cnt_nxt = ivl_cnt_r - 1'b1;
          end
        end else begin
          res.clock_pulse  = 1'b1;
          res.data_out_bit = out_shift_r[mecm_pkg::FRAME_BITS-1];
          out_shift_nxt    = {out_shift_r[mecm_pkg::FRAME_BITS-2:0], 1'b0};
          if (cmd_r == mecm_pkg::CMD_READ && bit_cnt_r <= mecm_pkg::DATA_CNT) begin
            in_shift_nxt = {in_shift_r[mecm_pkg::DATA_BITS-2:0], q_item.sdo};
          end
          bit_cnt_nxt = bit_cnt_r - 1'b1;
          if (bit_cnt_nxt == '0) begin
            done = 1'b1;
            if (cmd_r == mecm_pkg::CMD_READ) begin
              res.read_value = in_shift_nxt;
            end
          end
        end
        res.frame_done = done;
        if (done) begin
          active_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poll_interval_r <= mecm_pkg::POLL_INTERVAL_RST;
      poll_limit_r    <= mecm_pkg::POLL_LIMIT_RST;
      active_r        <= 1'b0;
      cmd_r           <= '0;
      out_shift_r     <= '0;
      bit_cnt_r       <= '0;
      in_shift_r      <= '0;
      poll_rem_r      <= '0;
      ivl_cnt_r       <= '0;
    end else begin
      if (cfg_we && cfg_index == mecm_pkg::CFG_POLL_INTERVAL) begin
        poll_interval_r <= cfg_data;
      end
      if (cfg_we && cfg_index == mecm_pkg::CFG_POLL_LIMIT) begin
        poll_limit_r <= cfg_data;
      end
      active_r    <= active_nxt;
      cmd_r       <= cmd_nxt;
      out_shift_r <= out_shift_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      in_shift_r  <= in_shift_nxt;
      poll_rem_r  <= poll_rem_nxt;
      ivl_cnt_r   <= ivl_cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/mecm_outq.sv =====
// ----------------------------------------------------------------------------
// mecm_outq - result queue
// Two-entry queue of pin-slot results between the engine and the user.
// ----------------------------------------------------------------------------
`default_nettype none

module mecm_outq (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire mecm_pkg::res_t  din,
  output logic                 full,
  output logic                 empty,
  input  wire logic            pop,
  output mecm_pkg::res_t       dout
);

  mecm_pkg::res_t mem_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           pop_en;

  assign full   = (cnt_r == 2'd2);
  assign empty  = (cnt_r == 2'd0);
  assign pop_en = pop && !empty;
  assign dout   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop_en;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop_en};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

`default_nettype wire

// ===== src/microwire_eeprom_command_master.sv =====
// ----------------------------------------------------------------------------
// microwire_eeprom_command_master - serial EEPROM command master
// Turns command and tick items into per-slot pin levels for a three-wire
// serial EEPROM: frame shifting, read assembly and busy polling.
// ----------------------------------------------------------------------------
// Usage: push a command item (in_func = 0) to open a frame, then one tick
// item (in_func = 1) per bit-clock slot; each tick yields exactly one
// result transfer carrying select, data, clock pulse and end-of-frame
// flags, while command items yield none. A command pushed while a frame is
// open, or command code 7, is dropped. Throughput is one item per clock on
// both sides while the result side is not stalled; a tick is registered in
// the input queue, then the engine pushes its result into the result
// queue, whose head drives the result ports. Both queues are two entries
// deep, so in_full only rises when the result side is stalled. Write
// poll_interval and poll_limit only while no frame is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module microwire_eeprom_command_master (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // configuration
  input  wire logic                            cfg_we,
  input  wire logic                            cfg_index,
  input  wire logic [mecm_pkg::CFG_BITS-1:0]   cfg_data,
  // input items
  input  wire logic                            in_push,
  output logic                                 in_full,
  input  wire logic                            in_func,
  input  wire logic [2:0]                      in_command,
  input  wire logic [mecm_pkg::ADDR_BITS-1:0]  in_address,
  input  wire logic [mecm_pkg::DATA_BITS-1:0]  in_write_data,
  input  wire logic                            in_sdo,
  // results
  output logic                                 out_empty,
  input  wire logic                            out_pop,
  output logic                                 out_chip_select,
  output logic                                 out_data_out_bit,
  output logic                                 out_clock_pulse,
  output logic                                 out_frame_done,
  output logic [mecm_pkg::DATA_BITS-1:0]       out_read_value,
  output logic                                 out_status
);

  logic            q_valid;
  logic            q_pop;
  mecm_pkg::item_t q_item;
  logic            res_full;
  logic            res_push;
  mecm_pkg::res_t  res;
  mecm_pkg::res_t  head;

  // front: classify and buffer
  mecm_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_func       (in_func),
    .in_command    (in_command),
    .in_address    (in_address),
    .in_write_data (in_write_data),
    .in_sdo        (in_sdo),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop)
  );

  // back: frame sequencing, one item per cycle; ticks wait on a full outq
  mecm_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  // holds up to two results so the engine can run on while the reader stalls
  mecm_outq u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res),
    .full  (res_full),
    .empty (out_empty),
    .pop   (out_pop),
    .dout  (head)
  );

  assign out_chip_select  = head.chip_select;
  assign out_data_out_bit = head.data_out_bit;
  assign out_clock_pulse  = head.clock_pulse;
  assign out_frame_done   = head.frame_done;
  assign out_read_value   = head.read_value;
  assign out_status       = head.status;

endmodule

`default_nettype wire

// ===== tb/sv/microwire_eeprom_command_master_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// microwire_eeprom_command_master_tb - self-checking bench for the command master
// Pushes command and tick items through the input queue and pops the per-slot
// pin levels. A local model of the frame shifter, read assembler and busy
// poller predicts every slot. A short scripted run covers the corner cases,
// then random frames follow under several poll settings.
// ----------------------------------------------------------------------------

module microwire_eeprom_command_master_tb;
  import mecm_pkg::*;

  // the one command code the package leaves unnamed; the block drops it
  localparam logic [2:0] CMD_UNKNOWN = 3'd7;

  // start bit and opcode as they should appear on the wire
  localparam logic [2:0] WIRE_READ  = 3'b110;
  localparam logic [2:0] WIRE_WRITE = 3'b101;
  localparam logic [2:0] WIRE_EXT   = 3'b100;
  localparam logic [2:0] WIRE_ERASE = 3'b111;

  localparam int unsigned RANDOM_ITEMS = 1400;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 4;     // input queue, engine, margin

  // slot levels that can be read straight off the spec
  localparam res_t SLOT_IDLE    = '0;
  localparam res_t SLOT_TIMEOUT = '{1'b1, 1'b0, 1'b0, 1'b1, 16'h0000, 1'b1};

  typedef enum logic [1:0] {
    ROW_CMD,
    ROW_TICKS,
    ROW_CFG
  } row_kind_t;

  // ROW_CFG: addr[0] is the register index, data the value
  // ROW_TICKS: tick k drives sdo_pat[k % 32]
  typedef struct {
    row_kind_t             kind;
    logic [2:0]            cmd;
    logic [ADDR_BITS-1:0]  addr;
    logic [DATA_BITS-1:0]  data;
    int unsigned           reps;
    logic [31:0]           sdo_pat;
    bit                    typed;
    res_t                  want;
  } script_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic                  cfg_index = CFG_POLL_INTERVAL;
  logic [CFG_BITS-1:0]   cfg_data = '0;
  logic                  in_push = 1'b0;
  logic                  in_full;
  logic                  in_func = 1'b0;
  logic [2:0]            in_command = CMD_READ;
  logic [ADDR_BITS-1:0]  in_address = '0;
  logic [DATA_BITS-1:0]  in_write_data = '0;
  logic                  in_sdo = 1'b0;
  logic                  out_empty;
  logic                  out_pop = 1'b0;
  logic                  out_chip_select;
  logic                  out_data_out_bit;
  logic                  out_clock_pulse;
  logic                  out_frame_done;
  logic [DATA_BITS-1:0]  out_read_value;
  logic                  out_status;

  // expected slot levels, oldest first
  res_t          slot_q[$];
  script_row_t   script[$];
  int unsigned   items_done = 0;
  int unsigned   fail_count = 0;
  int unsigned   cycles = 0;

  // stretch with neither gaps on the push side nor stalls on the pop side
  wire calm = (items_done >= 700) && (items_done < 1000);

  // local copy of the block's state and registers
  logic [CFG_BITS-1:0]    interval_reg = 16'd100;
  logic [CFG_BITS-1:0]    limit_reg    = 16'd10000;
  logic                   link_busy    = 1'b0;
  logic [2:0]             frame_cmd    = CMD_READ;
  logic [FRAME_BITS-1:0]  tx_bits      = '0;
  logic [4:0]             slots_left   = '0;
  logic [DATA_BITS-1:0]   rx_word      = '0;
  logic [15:0]            polls_left   = '0;
  logic [15:0]            poll_wait    = '0;

  microwire_eeprom_command_master uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_func          (in_func),
    .in_command       (in_command),
    .in_address       (in_address),
    .in_write_data    (in_write_data),
    .in_sdo           (in_sdo),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_chip_select  (out_chip_select),
    .out_data_out_bit (out_data_out_bit),
    .out_clock_pulse  (out_clock_pulse),
    .out_frame_done   (out_frame_done),
    .out_read_value   (out_read_value),
    .out_status       (out_status)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Opens a frame unless one is already running. Returns 1 if it did.
  function automatic bit open_frame(input logic [2:0] cmd, input logic [ADDR_BITS-1:0] addr,
                                    input logic [DATA_BITS-1:0] data);
    logic [4:0] len;
    if (link_busy)
      return 1'b0;
    len = 5'(3 + ADDR_BITS);
    case (cmd)
      CMD_READ: begin
        tx_bits = {WIRE_READ, addr, {DATA_BITS{1'b0}}};
        len     = 5'(FRAME_BITS);
      end
      CMD_WRITE: begin
        tx_bits = {WIRE_WRITE, addr, data};
        len     = 5'(FRAME_BITS);
      end
      CMD_EWEN:  tx_bits = {WIRE_EXT, 2'b11, {(ADDR_BITS-2){1'b0}}, {DATA_BITS{1'b0}}};
      CMD_EWDS:  tx_bits = {WIRE_EXT, {ADDR_BITS{1'b0}}, {DATA_BITS{1'b0}}};
      CMD_ERASE: tx_bits = {WIRE_ERASE, addr, {DATA_BITS{1'b0}}};
      CMD_ERAL:  tx_bits = {WIRE_EXT, 2'b10, {(ADDR_BITS-2){1'b0}}, {DATA_BITS{1'b0}}};
      CMD_BUSY: begin
        tx_bits = '0;
        len     = '0;
      end
      default: return 1'b0;
    endcase
    link_busy  = 1'b1;
    frame_cmd  = cmd;
    slots_left = len;
    rx_word    = '0;
    polls_left = limit_reg;
    poll_wait  = '0;
    return 1'b1;
  endfunction

  // One bit-clock slot: pin levels and the state step behind them.
  function automatic res_t eeprom_slot(input logic sdo);
    res_t r;
    r = '0;
    if (link_busy) begin
      r.chip_select = 1'b1;
      if (frame_cmd == CMD_BUSY) begin
        // no clock and no data while polling; the limit wins over a ready sample
        if (poll_wait == 0) begin
          polls_left = polls_left - 16'd1;
          if (polls_left == 0) begin
            r.frame_done = 1'b1;
            r.status     = 1'b1;
          end else if (sdo) begin
            r.frame_done = 1'b1;
          end else begin
            poll_wait = (interval_reg == 0) ? 16'd0 : interval_reg - 16'd1;
          end
        end else begin
          poll_wait = poll_wait - 16'd1;
        end
      end else begin
        r.clock_pulse  = 1'b1;
        r.data_out_bit = tx_bits[FRAME_BITS-1];
        tx_bits        = tx_bits << 1;
        // read data is clocked in during the last DATA_BITS slots
        if (frame_cmd == CMD_READ && slots_left <= DATA_BITS)
          rx_word = {rx_word[DATA_BITS-2:0], sdo};
        slots_left = slots_left - 5'd1;
        if (slots_left == 0) begin
          r.frame_done = 1'b1;
          if (frame_cmd == CMD_READ)
            r.read_value = rx_word;
        end
      end
      if (r.frame_done)
        link_busy = 1'b0;
    end
    return r;
  endfunction

  // Pushes one item, gaps at random, holds until the transfer, then predicts.
  task automatic send_item(input logic func, input logic [2:0] cmd,
                           input logic [ADDR_BITS-1:0] addr, input logic [DATA_BITS-1:0] data,
                           input logic sdo, input bit typed, input res_t want);
    res_t slot;
    @(negedge clk);
    while (!calm && $urandom_range(99) < 27) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push       <= 1'b1;
    in_func       <= func;
    in_command    <= cmd;
    in_address    <= addr;
    in_write_data <= data;
    in_sdo        <= sdo;
    @(posedge clk);
    while (in_full)
      @(posedge clk);
    if (func == ITEM_START) begin
      // a dropped command does not count as stimulus
      if (open_frame(cmd, addr, data))
        items_done++;
    end else begin
      slot = eeprom_slot(sdo);
      slot_q.push_back(typed ? want : slot);
      items_done++;
    end
  endtask

  task automatic send_tick(input logic sdo, input bit typed, input res_t want);
    send_item(ITEM_TICK, 3'($urandom), ADDR_BITS'($urandom), DATA_BITS'($urandom),
              sdo, typed, want);
  endtask

  // Register write once the block has gone quiet.
  task automatic set_reg(input logic idx, input logic [CFG_BITS-1:0] val);
    @(negedge clk);
    in_push <= 1'b0;
    while (slot_q.size() != 0)
      @(negedge clk);
    // a trailing dropped command may still be in the pipe
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_POLL_INTERVAL)
      interval_reg = val;
    else
      limit_reg = val;
  endtask

  task automatic plan(input row_kind_t kind, input logic [2:0] cmd,
                      input logic [ADDR_BITS-1:0] addr, input logic [DATA_BITS-1:0] data,
                      input int unsigned reps, input logic [31:0] sdo_pat,
                      input bit typed, input res_t want);
    script_row_t row;
    row = '{kind, cmd, addr, data, reps, sdo_pat, typed, want};
    script.push_back(row);
  endtask

  // Pop side: stall at random outside the calm stretch.
  always @(negedge clk)
    out_pop <= calm || ($urandom_range(99) >= 27);

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  // Each popped transfer is held against the oldest expectation.
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (slot_q.size() == 0) begin
        $error("result transfer with nothing expected");
        fail_count++;
      end else begin
        want = slot_q.pop_front();
        check_field("chip_select", want.chip_select, out_chip_select);
        check_field("data_out_bit", want.data_out_bit, out_data_out_bit);
        check_field("clock_pulse", want.clock_pulse, out_clock_pulse);
        check_field("frame_done", want.frame_done, out_frame_done);
        check_field("read_value", want.read_value, out_read_value);
        check_field("status", want.status, out_status);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int unsigned  target;
    int unsigned  phase;
    bit           ready_always;
    logic [15:0]  ival;
    logic [15:0]  lim;
    logic [2:0]   cmd;
    logic         sdo;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // ---- scripted corner cases ----
    // idle ticks give all-zero slots; an unknown command is dropped
    plan(ROW_TICKS, CMD_READ, '0, '0, 2, '0, 1'b1, SLOT_IDLE);
    plan(ROW_CMD, CMD_UNKNOWN, '1, '1, 0, '0, 1'b0, SLOT_IDLE);
    plan(ROW_TICKS, CMD_READ, '0, '0, 1, '0, 1'b1, SLOT_IDLE);
    // read at the top address; the write pushed mid-frame must be dropped
    plan(ROW_CMD, CMD_READ, '1, '0, 0, '0, 1'b0, SLOT_IDLE);
    plan(ROW_CMD, CMD_WRITE, '0, '1, 0, '0, 1'b0, SLOT_IDLE);
    plan(ROW_TICKS, CMD_READ, '0, '0, FRAME_BITS, '1, 1'b0, SLOT_IDLE);
    plan(ROW_CMD, CMD_READ, '0, '0, 0, '0, 1'b0, SLOT_IDLE);
    plan(ROW_TICKS, CMD_READ, '0, '0, FRAME_BITS, 32'h5555_5555, 1'b0, SLOT_IDLE);
    // writes with data at both extremes
    plan(ROW_CMD, CMD_WRITE, '0, '1, 0, '0, 1'b0, SLOT_IDLE);
    plan(ROW_TICKS, CMD_READ, '0, '0, FRAME_BITS, '0, 1'b0, SLOT_IDLE);
    plan(ROW_CMD, CMD_WRITE, '1, '0, 0, '0, 1'b0, SLOT_IDLE);
    plan(ROW_TICKS, CMD_READ, '0, '0, FRAME_BITS, '1, 1'b0, SLOT_IDLE);
    // the short frames with their fixed address patterns
    plan(ROW_CMD, CMD_EWEN, '1, '1, 0, '0, 1'b0, SLOT_IDLE);
    plan(ROW_TICKS, CMD_READ, '0, '0, 3 + ADDR_BITS, '1, 1'b0, SLOT_IDLE);
    plan(ROW_CMD, CMD_EWDS, '1, '1, 0, '0, 1'b0, SLOT_IDLE);
    plan(ROW_TICKS, CMD_READ, '0, '0, 3 + ADDR_BITS, '1, 1'b0, SLOT_IDLE);
    plan(ROW_CMD, CMD_ERASE, 10'h2AA, '1, 0, '0, 1'b0, SLOT_IDLE);
    plan(ROW_TICKS, CMD_READ, '0, '0, 3 + ADDR_BITS, '0, 1'b0, SLOT_IDLE);
    plan(ROW_CMD, CMD_ERAL, '0, '1, 0, '0, 1'b0, SLOT_IDLE);
    plan(ROW_TICKS, CMD_READ, '0, '0, 3 + ADDR_BITS, '0, 1'b0, SLOT_IDLE);
    // limit of one: the first sample times out even though the device is ready
    plan(ROW_CFG, CMD_READ, ADDR_BITS'(CFG_POLL_LIMIT), 16'd1, 0, '0, 1'b0, SLOT_IDLE);
    plan(ROW_CMD, CMD_BUSY, '0, '0, 0, '0, 1'b0, SLOT_IDLE);
    plan(ROW_TICKS, CMD_READ, '0, '0, 1, '1, 1'b1, SLOT_TIMEOUT);
    plan(ROW_TICKS, CMD_READ, '0, '0, 1, '1, 1'b1, SLOT_IDLE);
    // three samples two slots apart, never ready
    plan(ROW_CFG, CMD_READ, ADDR_BITS'(CFG_POLL_LIMIT), 16'd3, 0, '0, 1'b0, SLOT_IDLE);
    plan(ROW_CFG, CMD_READ, ADDR_BITS'(CFG_POLL_INTERVAL), 16'd2, 0, '0, 1'b0, SLOT_IDLE);
    plan(ROW_CMD, CMD_BUSY, '0, '0, 0, '0, 1'b0, SLOT_IDLE);
    plan(ROW_TICKS, CMD_READ, '0, '0, 7, '0, 1'b0, SLOT_IDLE);
    // zero interval samples every slot; zero limit wraps, ready on the fifth
    plan(ROW_CFG, CMD_READ, ADDR_BITS'(CFG_POLL_INTERVAL), 16'd0, 0, '0, 1'b0, SLOT_IDLE);
    plan(ROW_CFG, CMD_READ, ADDR_BITS'(CFG_POLL_LIMIT), 16'd0, 0, '0, 1'b0, SLOT_IDLE);
    plan(ROW_CMD, CMD_BUSY, '0, '0, 0, '0, 1'b0, SLOT_IDLE);
    plan(ROW_TICKS, CMD_READ, '0, '0, 5, 32'h0000_0010, 1'b0, SLOT_IDLE);

    foreach (script[i]) begin
      case (script[i].kind)
        ROW_CFG: set_reg(script[i].addr[0], script[i].data);
        ROW_CMD: send_item(ITEM_START, script[i].cmd, script[i].addr, script[i].data, 1'b0,
                           1'b0, SLOT_IDLE);
        default: begin
          for (int unsigned k = 0; k < script[i].reps; k++)
            send_tick(script[i].sdo_pat[k % 32], script[i].typed, script[i].want);
        end
      endcase
    end

    // ---- random frames under changing poll settings ----
    target = items_done + RANDOM_ITEMS;
    phase  = 0;
    while (items_done < target) begin
      // long intervals only with a device that answers on the first sample
      case ((phase == 0) ? 0 : $urandom_range(7))
        0: begin
          ival = '1;
          lim  = '1;
          ready_always = 1'b1;
        end
        1: begin
          ival = '1;
          lim  = 16'($urandom_range(1, 3));
          ready_always = 1'b1;
        end
        2, 3, 4: begin
          ival = 16'($urandom_range(1, 6));
          lim  = 16'($urandom_range(1, 10));
          ready_always = 1'b0;
        end
        default: begin
          ival = 16'($urandom_range(1, 4));
          lim  = 16'($urandom_range(9000, 65535));
          ready_always = 1'b0;
        end
      endcase
      set_reg(CFG_POLL_INTERVAL, ival);
      set_reg(CFG_POLL_LIMIT, lim);

      repeat ($urandom_range(4, 12)) begin
        repeat ($urandom_range(2)) send_tick(1'($urandom), 1'b0, SLOT_IDLE);
        cmd = ($urandom_range(19) == 0) ? CMD_UNKNOWN : 3'($urandom_range(6));
        send_item(ITEM_START, cmd, ADDR_BITS'($urandom), DATA_BITS'($urandom), 1'($urandom),
                  1'b0, SLOT_IDLE);
        while (link_busy) begin
          // now and then a command arrives mid-frame and must be dropped
          if ($urandom_range(29) == 0)
            send_item(ITEM_START, 3'($urandom), ADDR_BITS'($urandom), DATA_BITS'($urandom),
                      1'($urandom), 1'b0, SLOT_IDLE);
          if (frame_cmd == CMD_BUSY)
            sdo = ready_always || ($urandom_range(4) == 0);
          else
            sdo = 1'($urandom);
          send_tick(sdo, 1'b0, SLOT_IDLE);
        end
      end
      phase++;
    end

    @(negedge clk);
    in_push <= 1'b0;
    while (slot_q.size() != 0)
      @(posedge clk);
    repeat (2 * DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && slot_q.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

// ===== microwire_eeprom_command_master.f =====
src/mecm_pkg.sv
src/mecm_front.sv
src/mecm_engine.sv
src/mecm_outq.sv
src/microwire_eeprom_command_master.sv
tb/sv/microwire_eeprom_command_master_tb.sv
